@@ design/sbe_pkg.sv @@
// Shared types and constants of the stack bytecode executor.
// Holds the item structs, opcode codes, stack cell selects and ALU request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

   localparam int STACK_DEPTH_DEF    = 128;
   localparam int VAR_COUNT_DEF      = 256;
   localparam int PROG_ADDR_BITS_DEF = 16;

   localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TRUE_VALUE = 64'hFFFF_FFFF_0000_0000;

   typedef enum logic [4:0] {
      OP_NOP     = 5'd0,
      OP_PUSH    = 5'd1,
      OP_LOAD    = 5'd2,
      OP_STORE   = 5'd3,
      OP_ADD     = 5'd4,
      OP_SUB     = 5'd5,
      OP_MUL     = 5'd6,
      OP_DIV     = 5'd7,
      OP_MOD     = 5'd8,
      OP_NEG     = 5'd9,
      OP_EQ      = 5'd10,
      OP_NE      = 5'd11,
      OP_LT      = 5'd12,
      OP_GT      = 5'd13,
      OP_LE      = 5'd14,
      OP_GE      = 5'd15,
      OP_JMP     = 5'd16,
      OP_JZ      = 5'd17,
      OP_JNZ     = 5'd18,
      OP_FOR     = 5'd19,
      OP_PRINT   = 5'd20,
      OP_NEWLINE = 5'd21,
      OP_HALT    = 5'd22
   } op_type;

   typedef struct packed {
      logic [4:0]         op;
      logic signed [63:0] immediate;
      logic signed [63:0] loop_limit;
      logic [7:0]         var_index;
      logic [15:0]        jump_target;
   } req_type;

   typedef struct packed {
      logic               branch_taken;
      logic [15:0]        branch_address;
      logic               print_valid;
      logic signed [63:0] print_value;
      logic               newline;
      logic               halted;
      logic [7:0]         stack_depth;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_HOLD = 2'd0,
      SEL_PREV = 2'd1,
      SEL_NEXT = 2'd2
   } cell_sel_type;

   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1,
      ALU_MOD = 2'd2
   } alu_kind_type;

   typedef struct packed {
      logic         start;
      alu_kind_type kind;
      logic [63:0]  a;
      logic [63:0]  b;
   } alu_req_type;

endpackage

`default_nettype wire

@@ design/sbe_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/sbe_cell.sv @@
// One operand stack cell: holds an entry and takes its neighbor's on a shift.
// Depends on sbe_pkg for the select codes.
`timescale 1ns / 1ps
`default_nettype none

module sbe_cell
   import sbe_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_sel_type sel,
   input  wire logic [63:0]  prev_value,
   input  wire logic [63:0]  next_value,
   output logic      [63:0]  value
);

   logic [63:0] value_ff;
   logic [63:0] value_in;

   always_comb begin
      unique case (sel)
         SEL_PREV: value_in = prev_value;
         SEL_NEXT: value_in = next_value;
         default:  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

@@ design/sbe_alu.sv @@
// Iterative Q32.32 multiply, divide and integer modulo unit.
// Depends on sbe_pkg for the request struct and saturation constants.
`timescale 1ns / 1ps
`default_nettype none

module sbe_alu
   import sbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type alu_req,
   output logic             done,
   output logic [63:0]      result
);

   typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_type;

   function automatic logic [63:0] magnitude(input logic [63:0] x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                            input logic over);
      if (neg) begin
         return (over || (m > SIGN_BIT)) ? SIGN_BIT : (~m + 64'd1);
      end
      return (over || (m > MAX_POS)) ? MAX_POS : m;
   endfunction

   alu_state_type state_ff;
   alu_kind_type  kind_ff;
   logic          neg_ff;
   logic [63:0]   ma_ff;
   logic [63:0]   mb_ff;
   logic [6:0]    cnt_ff;
   logic [63:0]   prod_ff;
   logic [127:0]  acc_ff;
   logic [95:0]   dvd_ff;
   logic [63:0]   rem_ff;
   logic [63:0]   q_ff;
   logic          over_ff;
   logic          bzero_ff;
   logic [63:0]   res_ff;
   logic          done_ff;

   logic [63:0]  start_ma;
   logic [63:0]  start_mb;
   logic [63:0]  div_mb;
   logic [31:0]  mul_x;
   logic [31:0]  mul_y;
   logic [127:0] pp_shifted;
   logic [64:0]  rem_shift;
   logic         rem_ge;
   logic [64:0]  rem_diff;
   logic [63:0]  mod_r;
   logic [63:0]  fin_res;

   always_comb begin
      start_ma = magnitude(alu_req.a);
      start_mb = magnitude(alu_req.b);
      div_mb   = (alu_req.kind == ALU_DIV) ? start_mb : {32'd0, start_mb[63:32]};

      unique case (cnt_ff[1:0])
         2'd0: begin mul_x = ma_ff[31:0];  mul_y = mb_ff[31:0];  end
         2'd1: begin mul_x = ma_ff[63:32]; mul_y = mb_ff[31:0];  end
         2'd2: begin mul_x = ma_ff[31:0];  mul_y = mb_ff[63:32]; end
         default: begin mul_x = ma_ff[63:32]; mul_y = mb_ff[63:32]; end
      endcase

      // The partial product in prod_ff belongs to step cnt_ff - 1.
      unique case (cnt_ff[2:0])
         3'd1:    pp_shifted = {64'd0, prod_ff};
         3'd2,
         3'd3:    pp_shifted = {32'd0, prod_ff, 32'd0};
         3'd4:    pp_shifted = {prod_ff, 64'd0};
         default: pp_shifted = '0;
      endcase

      rem_shift = {rem_ff, dvd_ff[95]};
      rem_ge    = rem_shift >= {1'b0, mb_ff};
      rem_diff  = rem_shift - {1'b0, mb_ff};

      mod_r = {rem_ff[31:0], 32'd0};
      unique case (kind_ff)
         ALU_MUL: fin_res = from_mag(neg_ff, acc_ff[95:32], acc_ff[127:96] != 32'd0);
         ALU_DIV: fin_res = bzero_ff ? 64'd0 : from_mag(neg_ff, q_ff, over_ff);
         default: fin_res = bzero_ff ? 64'd0 : (neg_ff ? (~mod_r + 64'd1) : mod_r);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == A_FIN);
         unique case (state_ff)
            A_IDLE: begin
               if (alu_req.start) begin
                  kind_ff <= alu_req.kind;
                  cnt_ff  <= '0;
                  ma_ff   <= start_ma;
                  if (alu_req.kind == ALU_MUL) begin
                     neg_ff   <= alu_req.a[63] ^ alu_req.b[63];
                     mb_ff    <= start_mb;
                     acc_ff   <= '0;
                     state_ff <= A_MUL;
                  end else begin
                     neg_ff   <= (alu_req.kind == ALU_DIV) ?
                                 (alu_req.a[63] ^ alu_req.b[63]) : alu_req.a[63];
                     mb_ff    <= div_mb;
                     bzero_ff <= div_mb == 64'd0;
                     dvd_ff   <= (alu_req.kind == ALU_DIV) ? {start_ma, 32'd0} :
                                 {64'd0, start_ma[63:32]};
                     rem_ff   <= '0;
                     q_ff     <= '0;
                     over_ff  <= 1'b0;
                     state_ff <= A_DIV;
                  end
               end
            end
            A_MUL: begin
               prod_ff <= 64'(mul_x * mul_y);
               acc_ff  <= acc_ff + pp_shifted;
               cnt_ff  <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd4) begin
                  state_ff <= A_FIN;
               end
            end
            A_DIV: begin
               rem_ff  <= rem_ge ? rem_diff[63:0] : rem_shift[63:0];
               over_ff <= over_ff | q_ff[63];
               q_ff    <= {q_ff[62:0], rem_ge};
               dvd_ff  <= {dvd_ff[94:0], 1'b0};
               cnt_ff  <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd95) begin
                  state_ff <= A_FIN;
               end
            end
            default: begin
               res_ff   <= fin_res;
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

@@ design/stack_bytecode_executor_top.sv @@
// Top level of the stack bytecode executor: sequencer, operand stack cells,
// variable store and arithmetic unit. Depends on sbe_pkg, sbe_cell, sbe_ram, sbe_alu.
//
// Usage: each item on the req_ channel is one instruction. The block executes
// it against its operand stack and variable store and returns exactly one item
// on the rsp_ channel with branch, print, newline, halt and stack depth fields.
// An outside sequencer fetches the next instruction from branch_address when
// branch_taken is set, and sequentially otherwise.
// Timing: an instruction is accepted in the idle state; the next cycle reads
// the variable store, whose registered read sets that step. Most instructions
// then commit in that step when the output register is free. Multiply runs four
// 32 by 32 partial products through one multiplier; divide and modulo run
// a restoring divider one quotient bit a cycle.
// The operand stack is a row of cells that shift toward or away from the top.
// Reset: a synchronous reset clears the stack pointer and then starts a
// clearing pass that writes zero into every variable entry while req_ready stays low.
// Stalls: the result sits in an output register. A new instruction is accepted
// while it waits; that instruction finishes its work and then waits, without
// touching any state, until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module stack_bytecode_executor_top
   import sbe_pkg::*;
#(
   parameter int STACK_DEPTH    = STACK_DEPTH_DEF,
   parameter int VAR_COUNT      = VAR_COUNT_DEF,
   parameter int PROG_ADDR_BITS = PROG_ADDR_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int VA_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
   localparam logic [15:0] ADDR_MASK =
      (PROG_ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PROG_ADDR_BITS) - 32'd1);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_ALU, S_COMMIT} state_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if ((a[63] == b[63]) && (r[63] != a[63])) begin
         return a[63] ? SIGN_BIT : MAX_POS;
      end
      return r;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if ((a[63] != b[63]) && (r[63] != a[63])) begin
         return a[63] ? SIGN_BIT : MAX_POS;
      end
      return r;
   endfunction

   function automatic logic less_than(input logic [63:0] a, input logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [VA_W-1:0] to_addr(input logic [7:0] v);
      logic [31:0] w;
      w = {24'd0, v};
      return w[VA_W-1:0];
   endfunction

   state_type       state_ff;
   req_type         item_ff;
   logic [SP_W-1:0] sp_ff;
   logic [SP_W-1:0] sp_in;
   logic [VA_W-1:0] clear_cnt_ff;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            rsp_valid_ff;

   logic [63:0]  cell_value [STACK_DEPTH];
   cell_sel_type sel_top;
   cell_sel_type sel_rest;
   logic [63:0]  top_load;

   logic            ram_wr_en;
   logic [VA_W-1:0] ram_wr_addr;
   logic [63:0]     ram_wr_data;
   logic [VA_W-1:0] ram_rd_addr;
   logic [63:0]     ram_rd_data;

   alu_req_type alu_req;
   logic        alu_done;
   logic [63:0] alu_result;

   logic        req_accept;
   logic        out_free;
   logic        is_alu_op;
   logic        alu_go;
   logic        commit;
   logic        sp_ge1;
   logic        sp_ge2;
   logic        sp_full;
   logic        vi_ok;
   logic [63:0] a_val;
   logic [63:0] b_val;
   logic [63:0] var_val;
   logic [63:0] for_sum;
   logic        for_branch;
   logic [63:0] bin_res;
   logic        branch;
   logic [31:0] sp_wide;

   assign req_ready  = state_ff == S_IDLE;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign b_val   = cell_value[0];
   assign a_val   = cell_value[1];
   assign sp_ge1  = sp_ff != '0;
   assign sp_ge2  = sp_ff >= SP_W'(2);
   assign sp_full = sp_ff == SP_W'(STACK_DEPTH);
   assign vi_ok   = {24'd0, item_ff.var_index} < 32'(VAR_COUNT);
   assign var_val = vi_ok ? ram_rd_data : 64'd0;

   // The FOR counter is stepped first, then compared with the limit in the
   // direction given by the sign of the step.
   assign for_sum    = sat_add(ram_rd_data, item_ff.immediate);
   assign for_branch = !item_ff.immediate[63] ? !less_than(item_ff.loop_limit, for_sum)
                                              : !less_than(for_sum, item_ff.loop_limit);

   assign is_alu_op = (item_ff.op == OP_MUL) || (item_ff.op == OP_DIV) ||
                      (item_ff.op == OP_MOD);
   assign alu_go    = is_alu_op && sp_ge2;
   assign commit    = ((state_ff == S_EXEC) && !alu_go && out_free) ||
                      ((state_ff == S_COMMIT) && out_free);

   always_comb begin
      alu_req.start = (state_ff == S_EXEC) && alu_go;
      alu_req.a     = a_val;
      alu_req.b     = b_val;
      unique case (item_ff.op)
         OP_MUL:  alu_req.kind = ALU_MUL;
         OP_DIV:  alu_req.kind = ALU_DIV;
         default: alu_req.kind = ALU_MOD;
      endcase
   end

   always_comb begin
      unique case (item_ff.op)
         OP_ADD:  bin_res = sat_add(a_val, b_val);
         OP_SUB:  bin_res = sat_sub(a_val, b_val);
         OP_EQ:   bin_res = (a_val == b_val) ? TRUE_VALUE : 64'd0;
         OP_NE:   bin_res = (a_val != b_val) ? TRUE_VALUE : 64'd0;
         OP_LT:   bin_res = less_than(a_val, b_val) ? TRUE_VALUE : 64'd0;
         OP_GT:   bin_res = less_than(b_val, a_val) ? TRUE_VALUE : 64'd0;
         OP_LE:   bin_res = !less_than(b_val, a_val) ? TRUE_VALUE : 64'd0;
         OP_GE:   bin_res = !less_than(a_val, b_val) ? TRUE_VALUE : 64'd0;
         default: bin_res = alu_result;
      endcase
   end

   // Instruction effects, applied only on the commit cycle, and the clearing writes in S_CLEAR.
   always_comb begin
      sel_top   = SEL_HOLD;
      sel_rest  = SEL_HOLD;
      top_load  = bin_res;
      sp_in     = sp_ff;
      branch    = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = to_addr(item_ff.var_index);
      ram_wr_data = b_val;
      rsp_in    = '0;
      unique case (item_ff.op)
         OP_PUSH, OP_LOAD: begin
            if (!sp_full) begin
               sel_top  = SEL_PREV;
               sel_rest = SEL_PREV;
               top_load = (item_ff.op == OP_PUSH) ? item_ff.immediate : var_val;
               sp_in    = sp_ff + SP_W'(1);
            end
         end
         OP_STORE: begin
            if (sp_ge1) begin
               sel_top   = SEL_NEXT;
               sel_rest  = SEL_NEXT;
               sp_in     = sp_ff - SP_W'(1);
               ram_wr_en = vi_ok;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE,
         OP_GE: begin
            if (sp_ge2) begin
               sel_top  = SEL_PREV;
               sel_rest = SEL_NEXT;
               sp_in    = sp_ff - SP_W'(1);
            end
         end
         OP_NEG: begin
            if (sp_ge1) begin
               sel_top  = SEL_PREV;
               top_load = (b_val == SIGN_BIT) ? MAX_POS : (~b_val + 64'd1);
            end
         end
         OP_JMP: branch = 1'b1;
         OP_JZ, OP_JNZ: begin
            if (sp_ge1) begin
               sel_top  = SEL_NEXT;
               sel_rest = SEL_NEXT;
               sp_in    = sp_ff - SP_W'(1);
               branch   = (item_ff.op == OP_JZ) ? (b_val == 64'd0) : (b_val != 64'd0);
            end
         end
         OP_FOR: begin
            if (vi_ok) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = for_sum;
               branch      = for_branch;
            end
         end
         OP_PRINT: begin
            if (sp_ge1) begin
               sel_top  = SEL_NEXT;
               sel_rest = SEL_NEXT;
               sp_in    = sp_ff - SP_W'(1);
               rsp_in.print_valid = 1'b1;
               rsp_in.print_value = b_val;
            end
         end
         OP_NEWLINE: rsp_in.newline = 1'b1;
         OP_HALT:    rsp_in.halted  = 1'b1;
         default: ;
      endcase
      if (!commit) begin
         sel_top   = SEL_HOLD;
         sel_rest  = SEL_HOLD;
         ram_wr_en = 1'b0;
      end
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = 64'd0;
      end
      sp_wide = 32'(sp_in);
      rsp_in.branch_taken   = branch;
      rsp_in.branch_address = branch ? (item_ff.jump_target & ADDR_MASK) : 16'd0;
      rsp_in.stack_depth    = sp_wide[7:0];
   end

   // Operand stack: cell 0 is the top entry.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         sbe_cell u_cell (
            .clock      (clock),
            .sel        (sel_top),
            .prev_value (top_load),
            .next_value (cell_value[1]),
            .value      (cell_value[0])
         );
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
         sbe_cell u_cell (
            .clock      (clock),
            .sel        (sel_rest),
            .prev_value (cell_value[i-1]),
            .next_value (64'd0),
            .value      (cell_value[i])
         );
      end else begin : g_mid
         sbe_cell u_cell (
            .clock      (clock),
            .sel        (sel_rest),
            .prev_value (cell_value[i-1]),
            .next_value (cell_value[i+1]),
            .value      (cell_value[i])
         );
      end
   end

   assign ram_rd_addr = req_accept ? to_addr(req_data.var_index)
                                   : to_addr(item_ff.var_index);

   sbe_ram #(
      .WIDTH (64),
      .DEPTH (VAR_COUNT)
   ) u_var_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sbe_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .done    (alu_done),
      .result  (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_cnt_ff <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_ff       <= rsp_in;
            rsp_valid_ff <= 1'b1;
            sp_ff        <= sp_in;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_cnt_ff <= clear_cnt_ff + VA_W'(1);
               if (clear_cnt_ff == VA_W'(VAR_COUNT - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  item_ff  <= req_data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (alu_go) begin
                  state_ff <= S_ALU;
               end else if (out_free) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_COMMIT;
               end
            end
            S_ALU: begin
               if (alu_done) begin
                  state_ff <= S_COMMIT;
               end
            end
            default: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   a_full_push_ignored: assert property (@(posedge clock) disable iff (reset)
      (commit && sp_full && (item_ff.op == OP_PUSH || item_ff.op == OP_LOAD))
      |=> $stable(sp_ff))
      else $error("push onto a full stack moved the stack pointer");

   a_alu_start_ok: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> (state_ff == S_EXEC) && sp_ge2)
      else $error("arithmetic unit started without two operands");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready && !commit)
      else $error("instruction taken during variable clearing");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      commit |-> out_free)
      else $error("result committed over an unread result");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the stack bytecode executor.
// Drives instructions through valid/ready, predicts every response with a
// fixed-point stack machine of its own and compares them. Depends on sbe_pkg.
`timescale 1ns / 1ps

module testbench;
   import sbe_pkg::*;

   localparam int STACK_MAX = STACK_DEPTH_DEF;
   localparam int VAR_MAX   = VAR_COUNT_DEF;
   localparam longint CYCLE_LIMIT = 2000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stack_bytecode_executor_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Clock with a 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the machine: stack, pointer and variable store.
   logic [63:0] shadow_stack [STACK_MAX];
   int          shadow_sp;
   logic [63:0] shadow_vars [VAR_MAX];

   // Responses predicted for accepted instructions, oldest first.
   rsp_type     pending_rsp [$];

   int          send_idle_pct;
   int          recv_idle_pct;
   int          mismatch_count;
   int          rsp_count;
   int          instr_count;
   longint      cycle_count;

   // Saturating fixed-point helpers.
   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SIGN_BIT : MAX_POS;
      return r;
   endfunction

   function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SIGN_BIT : MAX_POS;
      return r;
   endfunction

   function automatic logic [63:0] mag_of(logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   // Applies a sign to a wide magnitude and clamps it to the Q32.32 range.
   function automatic logic [63:0] signed_clamp(logic neg, logic [127:0] m);
      if (neg) return (m > {64'd0, SIGN_BIT}) ? SIGN_BIT : -m[63:0];
      return (m > {64'd0, MAX_POS}) ? MAX_POS : m[63:0];
   endfunction

   function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, mag_of(a)} * {64'd0, mag_of(b)}) >> 32;
      return signed_clamp(a[63] ^ b[63], p);
   endfunction

   function automatic logic [63:0] fixed_div(logic [63:0] a, logic [63:0] b);
      logic [127:0] q;
      if (b == 64'd0) return 64'd0;
      q = ({64'd0, mag_of(a)} << 32) / {64'd0, mag_of(b)};
      return signed_clamp(a[63] ^ b[63], q);
   endfunction

   function automatic logic [63:0] int_mod(logic [63:0] a, logic [63:0] b);
      logic [63:0] ia, ib, r;
      ia = mag_of(a) >> 32;
      ib = mag_of(b) >> 32;
      if (ib == 64'd0) return 64'd0;
      r = (ia % ib) << 32;
      return a[63] ? -r : r;
   endfunction

   function automatic logic compare_true(op_type op, logic [63:0] a, logic [63:0] b);
      case (op)
         OP_EQ: return a == b;
         OP_NE: return a != b;
         OP_LT: return $signed(a) < $signed(b);
         OP_GT: return $signed(a) > $signed(b);
         OP_LE: return $signed(a) <= $signed(b);
         default: return $signed(a) >= $signed(b);
      endcase
   endfunction

   // Executes one instruction on the shadow state and returns its response.
   function automatic rsp_type execute_instr(req_type r);
      rsp_type     o;
      logic [63:0] a, b, c, res;
      logic        idx_ok;
      op_type      op;
      o = '0;
      op = op_type'(r.op);
      idx_ok = r.var_index < VAR_MAX;
      case (op)
         OP_PUSH, OP_LOAD: begin
            if (shadow_sp < STACK_MAX) begin
               if (op == OP_PUSH) shadow_stack[shadow_sp] = r.immediate;
               else shadow_stack[shadow_sp] = idx_ok ? shadow_vars[r.var_index] : 64'd0;
               shadow_sp++;
            end
         end
         OP_STORE: begin
            if (shadow_sp > 0) begin
               shadow_sp--;
               if (idx_ok) shadow_vars[r.var_index] = shadow_stack[shadow_sp];
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
         OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE: begin
            if (shadow_sp >= 2) begin
               a = shadow_stack[shadow_sp - 2];
               b = shadow_stack[shadow_sp - 1];
               case (op)
                  OP_ADD:  res = sat_add(a, b);
                  OP_SUB:  res = sat_sub(a, b);
                  OP_MUL:  res = fixed_mul(a, b);
                  OP_DIV:  res = fixed_div(a, b);
                  OP_MOD:  res = int_mod(a, b);
                  default: res = compare_true(op, a, b) ? TRUE_VALUE : 64'd0;
               endcase
               shadow_stack[shadow_sp - 2] = res;
               shadow_sp--;
            end
         end
         OP_NEG: begin
            if (shadow_sp >= 1) begin
               a = shadow_stack[shadow_sp - 1];
               shadow_stack[shadow_sp - 1] = (a == SIGN_BIT) ? MAX_POS : -a;
            end
         end
         OP_JMP: o.branch_taken = 1'b1;
         OP_JZ, OP_JNZ: begin
            if (shadow_sp > 0) begin
               shadow_sp--;
               c = shadow_stack[shadow_sp];
               o.branch_taken = (op == OP_JZ) ? (c == 64'd0) : (c != 64'd0);
            end
         end
         OP_FOR: begin
            if (idx_ok) begin
               c = sat_add(shadow_vars[r.var_index], r.immediate);
               shadow_vars[r.var_index] = c;
               o.branch_taken = !r.immediate[63] ? ($signed(c) <= r.loop_limit)
                                                 : ($signed(c) >= r.loop_limit);
            end
         end
         OP_PRINT: begin
            if (shadow_sp > 0) begin
               shadow_sp--;
               o.print_valid = 1'b1;
               o.print_value = shadow_stack[shadow_sp];
            end
         end
         OP_NEWLINE: o.newline = 1'b1;
         OP_HALT:    o.halted = 1'b1;
         default: ;
      endcase
      if (o.branch_taken) o.branch_address = r.jump_target;
      o.stack_depth = shadow_sp[7:0];
      return o;
   endfunction

   // Offers one instruction, holding it until accepted; the sender may idle first.
   // Valid stays high after acceptance until the next call or a drain lowers it.
   task automatic send_instr(req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(execute_instr(r));
      instr_count++;
   endtask

   function automatic req_type make_instr(op_type op, logic [63:0] imm = 64'd0,
                                          logic [7:0] vi = 8'd0, logic [15:0] tgt = 16'd0,
                                          logic [63:0] lim = 64'd0);
      req_type r;
      r.op = op;
      r.immediate = imm;
      r.loop_limit = lim;
      r.var_index = vi;
      r.jump_target = tgt;
      return r;
   endfunction

   function automatic logic [63:0] rand_value();
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return {32'($signed($urandom_range(20)) - 10), 32'd0};
         2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
         3: return $urandom_range(1) ? SIGN_BIT : MAX_POS;
         4: return 64'd0;
         default: return {32'($signed($urandom_range(2000)) - 1000), $urandom};
      endcase
   endfunction

   function automatic req_type rand_instr();
      req_type r;
      r.op = 5'($urandom_range(31));
      // Bias toward pushes and arithmetic so the stack holds operands.
      if ($urandom_range(3) == 0) r.op = OP_PUSH;
      else if ($urandom_range(3) == 0) r.op = 5'($urandom_range(OP_MOD, OP_ADD));
      r.immediate = rand_value();
      r.loop_limit = rand_value();
      r.var_index = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(7));
      r.jump_target = 16'($urandom);
      return r;
   endfunction

   // Lowers req_valid and waits until every predicted response has been seen.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Response checker with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               rsp_type want;
               want = pending_rsp.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Boundary values, all opcodes but NOP and SUB, empty and full stack, zero divisors.
   task automatic test_directed();
      send_instr(make_instr(OP_PRINT));
      send_instr(make_instr(OP_ADD));
      send_instr(make_instr(OP_JZ, 0, 0, 16'hFFFF));
      send_instr(make_instr(OP_STORE, 0, 3));
      send_instr(make_instr(OP_PUSH, MAX_POS));
      send_instr(make_instr(OP_PUSH, MAX_POS));
      send_instr(make_instr(OP_ADD));
      send_instr(make_instr(OP_PUSH, SIGN_BIT));
      send_instr(make_instr(OP_NEG));
      send_instr(make_instr(OP_MUL));
      send_instr(make_instr(OP_PUSH, 64'd0));
      send_instr(make_instr(OP_DIV));
      send_instr(make_instr(OP_PUSH, 64'h0000_0007_8000_0000));
      send_instr(make_instr(OP_PUSH, 64'h0000_0000_8000_0000));
      send_instr(make_instr(OP_MOD));
      send_instr(make_instr(OP_PUSH, 64'hFFFF_FFFD_0000_0000));
      for (int op = OP_EQ; op <= OP_GE; op++) begin
         send_instr(make_instr(OP_PUSH, 64'h1));
         send_instr(make_instr(op_type'(op)));
      end
      send_instr(make_instr(OP_FOR, 64'h1_0000_0000, 8'd255, 16'h1234, 64'h3_0000_0000));
      send_instr(make_instr(OP_FOR, SIGN_BIT, 8'd9, 16'hFFFF, SIGN_BIT));
      send_instr(make_instr(OP_LOAD, 0, 8'd255));
      send_instr(make_instr(OP_JNZ, 0, 0, 16'h00AA));
      send_instr(make_instr(OP_JMP, 0, 0, 16'h5555));
      send_instr(make_instr(OP_NEWLINE));
      send_instr(make_instr(OP_HALT));
      send_instr(make_instr(op_type'(5'd31)));
      // Fill the stack past its depth, then empty it.
      for (int i = 0; i < STACK_MAX + 3; i++) send_instr(make_instr(OP_PUSH, rand_value()));
      for (int i = 0; i < STACK_MAX + 3; i++) send_instr(make_instr(OP_PRINT));
   endtask

   // Random instruction streams, with one pause until every response is back.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_responses();
         send_instr(rand_instr());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      mismatch_count = 0;
      rsp_count = 0;
      instr_count = 0;
      cycle_count = 0;
      shadow_sp = 0;
      foreach (shadow_vars[i]) shadow_vars[i] = 64'd0;
      foreach (shadow_stack[i]) shadow_stack[i] = 64'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 31;
      recv_idle_pct = 53;
      test_directed();
      test_random(350);
      send_idle_pct = 53;
      recv_idle_pct = 31;
      test_random(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(300);
      drain_responses();

      $display("Ran %0d instructions (all opcodes, stack limits, saturation, loops)",
               instr_count);
      $display("Checked %0d responses, %0d mismatches", rsp_count, mismatch_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
